// File: hdl/sfr_pkg.sv
// Shared constants, codes and interface types for the serial frame receiver.
package sfr_pkg;

   localparam int MAX_PAYLOAD = 16;
   localparam int HDR_LEN     = 5;
   localparam int POS_W       = $clog2(HDR_LEN + MAX_PAYLOAD + 1);
   localparam int IDX_W       = $clog2(MAX_PAYLOAD);
   localparam int LEN_W       = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int NUM_TYPES   = 8;

   localparam logic [7:0] CHECK_BASE   = 8'hFC;
   localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_PAYLOAD);

   localparam logic [7:0] SYNC_RESET       = 8'hFC;
   localparam logic [7:0] PRE_FIRST_RESET  = 8'h02;
   localparam logic [7:0] PRE_SECOND_RESET = 8'h7A;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_FIRST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_SECOND = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPES      = 2'd3;

   localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
   localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(1);
   localparam logic [POS_W-1:0] POS_PRE_1    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_PRE_2    = POS_W'(3);
   localparam logic [POS_W-1:0] POS_LENGTH   = POS_W'(4);
   localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(HDR_LEN);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FETCH,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic advance;
   } ctl_cmd_type;

   typedef struct packed {
      logic frame_good;
      logic empty;
      logic last;
   } dp_stat_type;

endpackage

// File: hdl/serial_frame_receiver.sv
// Top level of the serial frame receiver with additive checksum.
// While receiving, one byte item is taken per cycle, and frame bytes cause no results.
// After a good check byte, a store read state comes before the first result (none for an empty
// frame); each payload result is a store read, then an output, plus any stall.
// No byte is taken while a payload run is read out.
// Reset is synchronous: configuration returns to defaults and the parser hunts for sync.
module serial_frame_receiver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_frame_type,
   output logic [sfr_pkg::LEN_W-1:0]       rsp_payload_length,
   output logic [sfr_pkg::IDX_W-1:0]       rsp_byte_index,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_has_byte,
   output logic                            rsp_last,
   input  logic                            csr_write,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sfr_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfr_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .rx_byte        (req_rx_byte),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .frame_type     (rsp_frame_type),
      .payload_length (rsp_payload_length),
      .byte_index     (rsp_byte_index),
      .payload_byte   (rsp_payload_byte),
      .has_byte       (rsp_has_byte)
   );

   assign rsp_last = stat.last;

endmodule

// File: hdl/sfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sfr_datapath.sv
// Datapath: configuration registers, frame parsing state, checksum and payload store.
module sfr_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  sfr_pkg::ctl_cmd_type            cmd,
   output sfr_pkg::dp_stat_type            stat,
   input  logic [7:0]                      rx_byte,
   input  logic                            csr_write,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic [7:0]                      frame_type,
   output logic [sfr_pkg::LEN_W-1:0]       payload_length,
   output logic [sfr_pkg::IDX_W-1:0]       byte_index,
   output logic [7:0]                      payload_byte,
   output logic                            has_byte
);
   import sfr_pkg::*;

   logic [7:0]            sync_ff, pre_first_ff, pre_second_ff;
   logic [CSR_DATA_W-1:0] types_ff;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       type_ff, type_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic             type_ok;
   logic             frame_good;
   logic [POS_W-1:0] payload_end;
   logic [POS_W-1:0] slot;
   logic             wr_en;
   logic [7:0]       rd_data;
   logic [7:0]       sum_next;

   always_comb begin
      type_ok = 1'b0;
      for (int k = 0; k < NUM_TYPES; k++) begin
         if (types_ff[8*k +: 8] == rx_byte) begin
            type_ok = 1'b1;
         end
      end
   end

   assign payload_end = POS_PAYLOAD + POS_W'(len_ff);
   assign slot        = pos_ff - POS_PAYLOAD;
   assign sum_next    = sum_ff + rx_byte;

   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      sum_in     = sum_ff;
      type_in    = type_ff;
      wr_en      = 1'b0;
      frame_good = 1'b0;
      if (cmd.accept) begin
         if (pos_ff == POS_HUNT) begin
            if (rx_byte == sync_ff) begin
               sum_in = rx_byte;
               pos_in = POS_TYPE;
            end
         end else if (pos_ff == POS_TYPE) begin
            if (type_ok) begin
               type_in = rx_byte;
               sum_in  = sum_next;
               pos_in  = pos_ff + 1'b1;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_PRE_1) begin
            if (rx_byte == pre_first_ff) begin
               sum_in = sum_next;
               pos_in = pos_ff + 1'b1;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_PRE_2) begin
            if (rx_byte == pre_second_ff) begin
               sum_in = sum_next;
               pos_in = pos_ff + 1'b1;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff == POS_LENGTH) begin
            if (rx_byte <= MAX_LEN_BYTE) begin
               len_in = rx_byte[LEN_W-1:0];
               sum_in = sum_next;
               pos_in = pos_ff + 1'b1;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (pos_ff < payload_end) begin
            wr_en  = 1'b1;
            sum_in = sum_next;
            pos_in = pos_ff + 1'b1;
         end else begin
            pos_in     = POS_HUNT;
            frame_good = ((CHECK_BASE - sum_ff) == rx_byte);
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (frame_good) begin
         idx_in = '0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff       <= SYNC_RESET;
         pre_first_ff  <= PRE_FIRST_RESET;
         pre_second_ff <= PRE_SECOND_RESET;
         types_ff      <= '0;
         pos_ff        <= POS_HUNT;
         len_ff        <= '0;
         sum_ff        <= '0;
         type_ff       <= '0;
         idx_ff        <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SYNC:       sync_ff       <= csr_wdata[7:0];
               CSR_PRE_FIRST:  pre_first_ff  <= csr_wdata[7:0];
               CSR_PRE_SECOND: pre_second_ff <= csr_wdata[7:0];
               CSR_TYPES:      types_ff      <= csr_wdata;
               default: ;
            endcase
         end
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         sum_ff  <= sum_in;
         type_ff <= type_in;
         idx_ff  <= idx_in;
      end
   end

   sfr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot[IDX_W-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.fetch),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign stat.frame_good = frame_good;
   assign stat.empty      = (len_ff == '0);
   assign stat.last       = (len_ff == '0) || ((LEN_W'(idx_ff) + 1'b1) == len_ff);

   assign frame_type     = type_ff;
   assign payload_length = len_ff;
   assign byte_index     = idx_ff;
   assign has_byte       = (len_ff != '0);
   assign payload_byte   = has_byte ? rd_data : 8'h00;

endmodule

// File: hdl/sfr_ctrl.sv
// Controller: byte intake versus payload readout sequencing.
module sfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sfr_pkg::dp_stat_type  stat,
   output sfr_pkg::ctl_cmd_type  cmd
);
   import sfr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.fetch   = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (stat.frame_good) begin
               state_in = stat.empty ? ST_SEND : ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (stat.last) begin
                  state_in = ST_RUN;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

endmodule
